// ===== hdl/tblr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tblr_pkg: shared types and constants for the timer bank LED rotation
// Bank size, count width, action and register codes, control/status types.
// ----------------------------------------------------------------------------
package tblr_pkg;

  localparam int NUM_TIMERS = 8;
  localparam int COUNT_BITS = 16;
  localparam int TIDX_W     = $clog2(NUM_TIMERS);

  localparam int ACTION_W = 2;
  localparam int INDEX_W  = 3;
  localparam int DUR_W    = 16;
  localparam int LED_W    = 3;
  localparam int FLAGS_W  = 8;
  localparam int REM_W    = 16;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_START   = 2'd0,
    ACT_STOP    = 2'd1,
    ACT_TICK    = 2'd2,
    ACT_SERVICE = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE0 = 2'd0,
    CFG_PHASE1 = 2'd1,
    CFG_PHASE2 = 2'd2,
    CFG_NONE   = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SVC_STEP0 = 2'd0,
    SVC_STEP1 = 2'd1,
    SVC_STEP2 = 2'd2,
    SVC_NONE  = 2'd3
  } svc_step_t;

  localparam logic [LED_W-1:0] LED0_ONLY = 3'b001;
  localparam logic [LED_W-1:0] LED1_ONLY = 3'b010;
  localparam logic [LED_W-1:0] LED2_ONLY = 3'b100;

  // controller to datapath
  typedef struct packed {
    logic      capture;
    logic      exec;
    logic      svc;
    svc_step_t step;
    logic      load_out;
  } tblr_cmd_t;

  // datapath to controller
  typedef struct packed {
    action_t action;
  } tblr_stat_t;

endpackage

// ===== hdl/tblr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tblr_ctrl: sequencer for the timer bank
// Steps one item through execute and, for service, a three-step service scan, then response.
// ----------------------------------------------------------------------------
module tblr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  tblr_pkg::tblr_stat_t stat,
  output tblr_pkg::tblr_cmd_t  cmd
);
  import tblr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SVC0,
    ST_SVC1,
    ST_SVC2,
    ST_RESP
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat.action == ACT_SERVICE) begin
          state_nxt = ST_SVC0;
        end else begin
          state_nxt = ST_RESP;
        end
      end
      ST_SVC0: state_nxt = ST_SVC1;
      ST_SVC1: state_nxt = ST_SVC2;
      ST_SVC2: state_nxt = ST_RESP;
      ST_RESP: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.step     = SVC_NONE;
    cmd.capture  = (state_r == ST_IDLE) && start;
    // service items pass through EXEC with no effect
    cmd.exec     = (state_r == ST_EXEC) && (stat.action != ACT_SERVICE);
    cmd.load_out = (state_r == ST_RESP);
    case (state_r)
      ST_SVC0: begin
        cmd.svc  = 1'b1;
        cmd.step = SVC_STEP0;
      end
      ST_SVC1: begin
        cmd.svc  = 1'b1;
        cmd.step = SVC_STEP1;
      end
      ST_SVC2: begin
        cmd.svc  = 1'b1;
        cmd.step = SVC_STEP2;
      end
      default: begin
        cmd.svc  = 1'b0;
        cmd.step = SVC_NONE;
      end
    endcase
  end

endmodule

// ===== hdl/tblr_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tblr_dp: timer bank datapath
// Counters, expiry flags, LED register, phase durations and result registers.
// ----------------------------------------------------------------------------
module tblr_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  tblr_pkg::tblr_cmd_t                  cmd,
  output tblr_pkg::tblr_stat_t                 stat,
  input  logic [tblr_pkg::ACTION_W-1:0]        in_action,
  input  logic [tblr_pkg::INDEX_W-1:0]         in_timer_index,
  input  logic [tblr_pkg::DUR_W-1:0]           in_duration,
  input  logic                                 cfg_valid,
  input  logic [tblr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tblr_pkg::DUR_W-1:0]           cfg_data,
  output logic                                 out_valid,
  output logic [tblr_pkg::LED_W-1:0]           out_led_pattern,
  output logic [tblr_pkg::FLAGS_W-1:0]         out_event_flags,
  output logic [tblr_pkg::REM_W-1:0]           out_remaining
);
  import tblr_pkg::*;

  localparam int IDX_EXT_W = (TIDX_W > INDEX_W) ? TIDX_W : INDEX_W;
  localparam int NFLAG     = (NUM_TIMERS < FLAGS_W) ? NUM_TIMERS : FLAGS_W;

  // captured item
  action_t            action_r;
  logic [INDEX_W-1:0] index_r;
  logic [DUR_W-1:0]   dur_r;

  logic [COUNT_BITS-1:0] cnt_r [NUM_TIMERS];
  logic [COUNT_BITS-1:0] cnt_nxt [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] exp_r;
  logic [NUM_TIMERS-1:0] exp_nxt;
  logic [LED_W-1:0]      leds_r;
  logic [LED_W-1:0]      leds_nxt;
  logic [DUR_W-1:0]      phase_r [3];

  logic                  out_valid_r;
  logic [LED_W-1:0]      out_led_r;
  logic [FLAGS_W-1:0]    out_flags_r;
  logic [REM_W-1:0]      out_rem_r;

  logic [IDX_EXT_W-1:0]  idx_ext;
  logic [TIDX_W-1:0]     idx_sel;
  logic                  in_range;
  logic [COUNT_BITS-1:0] dur_cut;
  logic [COUNT_BITS-1:0] cur_cnt;

  logic [TIDX_W-1:0]     svc_cur;
  logic [TIDX_W-1:0]     svc_next;
  logic [LED_W-1:0]      svc_led;
  logic [COUNT_BITS-1:0] svc_load;
  logic [FLAGS_W-1:0]    flags_now;

  assign stat.action = action_r;

  assign idx_ext  = IDX_EXT_W'(index_r);
  assign idx_sel  = idx_ext[TIDX_W-1:0];
  assign in_range = (int'(index_r) < NUM_TIMERS);
  assign dur_cut  = COUNT_BITS'(dur_r);
  assign cur_cnt  = cnt_r[idx_sel];

  always_comb begin
    case (cmd.step)
      SVC_STEP0: begin
        svc_cur  = TIDX_W'(0);
        svc_next = TIDX_W'(1);
        svc_led  = LED1_ONLY;
        svc_load = COUNT_BITS'(phase_r[1]);
      end
      SVC_STEP1: begin
        svc_cur  = TIDX_W'(1);
        svc_next = TIDX_W'(2);
        svc_led  = LED2_ONLY;
        svc_load = COUNT_BITS'(phase_r[2]);
      end
      SVC_STEP2: begin
        svc_cur  = TIDX_W'(2);
        svc_next = TIDX_W'(0);
        svc_led  = LED0_ONLY;
        svc_load = COUNT_BITS'(phase_r[0]);
      end
      default: begin
        svc_cur  = TIDX_W'(0);
        svc_next = TIDX_W'(0);
        svc_led  = leds_r;
        svc_load = '0;
      end
    endcase
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    exp_nxt  = exp_r;
    leds_nxt = leds_r;
    if (cmd.exec && in_range) begin
      case (action_r)
        ACT_START: begin
          cnt_nxt[idx_sel] = dur_cut;
          exp_nxt[idx_sel] = (dur_cut == '0);
        end
        ACT_STOP: begin
          cnt_nxt[idx_sel] = '0;
          exp_nxt[idx_sel] = 1'b0;
        end
        ACT_TICK: begin
          if (cur_cnt != '0) begin
            cnt_nxt[idx_sel] = cur_cnt - COUNT_BITS'(1);
            exp_nxt[idx_sel] = (cur_cnt == COUNT_BITS'(1));
          end
        end
        default: begin
        end
      endcase
    end
    // one rotation phase per step; a zero load chains into the following step
    if (cmd.svc && exp_r[svc_cur]) begin
      leds_nxt          = svc_led;
      cnt_nxt[svc_next] = svc_load;
      exp_nxt[svc_next] = (svc_load == '0);
      exp_nxt[svc_cur]  = 1'b0;
    end
  end

  always_comb begin
    flags_now = '0;
    for (int i = 0; i < NFLAG; i++) begin
      flags_now[i] = exp_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      action_r <= action_t'(in_action);
      index_r  <= in_timer_index;
      dur_r    <= in_duration;
    end
    if (cmd.load_out) begin
      out_led_r   <= leds_r;
      out_flags_r <= flags_now;
      out_rem_r   <= in_range ? REM_W'(cur_cnt) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        cnt_r[i] <= '0;
      end
      exp_r       <= '0;
      leds_r      <= '0;
      phase_r[0]  <= DUR_W'(500);
      phase_r[1]  <= DUR_W'(500);
      phase_r[2]  <= DUR_W'(500);
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      exp_r       <= exp_nxt;
      leds_r      <= leds_nxt;
      out_valid_r <= cmd.load_out;
      if (cfg_valid) begin
        case (cfg_reg_t'(cfg_index))
          CFG_PHASE0: phase_r[0] <= cfg_data;
          CFG_PHASE1: phase_r[1] <= cfg_data;
          CFG_PHASE2: phase_r[2] <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_led_pattern = out_led_r;
  assign out_event_flags = out_flags_r;
  assign out_remaining   = out_rem_r;

endmodule

// ===== hdl/timer_bank_led_rotation.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_bank_led_rotation: timer bank with expiry flags and LED rotation
// Start/stop/tick one timer, or service flags of timers 0..2 in order.
// ----------------------------------------------------------------------------
// Sequence: start, stop and tick pass EXEC and RESP; service passes EXEC, then
//   SVC0, SVC1 and SVC2 (one sequencer step per rotation phase), then RESP.
// The result strobe is registered from RESP; busy is high until IDLE again, and only then is a new item taken.
// Results are strobed for one cycle; the receiver cannot stall.
// Reset (synchronous): counts, flags and LEDs zero, phase durations 500.
module timer_bank_led_rotation (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [tblr_pkg::ACTION_W-1:0]  in_action,
  input  logic [tblr_pkg::INDEX_W-1:0]   in_timer_index,
  input  logic [tblr_pkg::DUR_W-1:0]     in_duration,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tblr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tblr_pkg::DUR_W-1:0]     cfg_data,
  output logic                           out_valid,
  output logic [tblr_pkg::LED_W-1:0]     out_led_pattern,
  output logic [tblr_pkg::FLAGS_W-1:0]   out_event_flags,
  output logic [tblr_pkg::REM_W-1:0]     out_remaining
);
  import tblr_pkg::*;

  tblr_cmd_t  cmd;
  tblr_stat_t stat;

  assign cfg_ready = 1'b1;

  tblr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  tblr_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_action       (in_action),
    .in_timer_index  (in_timer_index),
    .in_duration     (in_duration),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_led_pattern (out_led_pattern),
    .out_event_flags (out_event_flags),
    .out_remaining   (out_remaining)
  );

endmodule

// ===== hdl/tblr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tblr_checker: port-level checks for the timer bank
// Strobe spacing, busy behavior and LED pattern shape.
// ----------------------------------------------------------------------------
module tblr_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic [tblr_pkg::LED_W-1:0]    out_led_pattern
);
  import tblr_pkg::*;

  // an item is in flight right after it is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy low after item accepted");

  // no result in the cycle right after an accept
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !out_valid)
    else $error("result strobe too early");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("busy while result is shown");

  a_one_led: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0(out_led_pattern))
    else $error("more than one LED lit");

endmodule

bind timer_bank_led_rotation tblr_checker u_tblr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_led_pattern (out_led_pattern)
);
